// ----- design/tbi_pkg.sv -----
package tbi_pkg;

    localparam int JOINTS   = 64;
    localparam int JOINT_W  = 6;
    localparam int POS_W    = 32;
    localparam int DIFF_W   = POS_W + 1;
    localparam int STEP_W   = 16;
    localparam int FRAC_W   = 24;
    localparam int S_W      = FRAC_W + 1;
    localparam int DIV_BITS = 4;
    localparam int DIV_STAGES = FRAC_W / DIV_BITS;

    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [S_W-1:0] ONE_Q = S_W'(1) << FRAC_W;

    // register index taken from paddr[2]
    localparam logic REG_BLEND_MODE    = 1'b0;
    localparam logic REG_SEGMENT_STEPS = 1'b1;

    localparam logic [STEP_W-1:0] SEGMENT_STEPS_RESET = 16'd100;

    typedef enum logic [1:0] {
        BLEND_LINEAR  = 2'd0,
        BLEND_CUBIC   = 2'd1,
        BLEND_QUINTIC = 2'd2
    } blend_mode_t;

    // fields that ride along the pipeline with each request
    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic signed [POS_W-1:0]  x0;
        logic signed [DIFF_W-1:0] diff;
        blend_mode_t              mode;
    } tbi_side_t;

endpackage

// ----- design/tbi_req_if.sv -----
interface tbi_req_if;
    import tbi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [JOINT_W-1:0]        joint_index;
    logic signed [POS_W-1:0]   start_pos;
    logic signed [POS_W-1:0]   end_pos;
    logic [STEP_W-1:0]         step_index;

    modport source (
        output valid,
        output joint_index,
        output start_pos,
        output end_pos,
        output step_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  joint_index,
        input  start_pos,
        input  end_pos,
        input  step_index,
        output ready
    );

endinterface

// ----- design/tbi_rsp_if.sv -----
interface tbi_rsp_if;
    import tbi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [JOINT_W-1:0]        joint_out;
    logic signed [POS_W-1:0]   position;

    modport source (
        output valid,
        output joint_out,
        output position,
        input  ready
    );

    modport sink (
        input  valid,
        input  joint_out,
        input  position,
        output ready
    );

endinterface

// ----- design/tbi_div.sv -----
module tbi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  tbi_pkg::tbi_side_t            side_in,
    input  logic [tbi_pkg::STEP_W-1:0]    step,
    input  logic [tbi_pkg::STEP_W-1:0]    seg_steps,
    output logic                          out_valid,
    output tbi_pkg::tbi_side_t            side_out,
    output logic [tbi_pkg::S_W-1:0]       s
);
    import tbi_pkg::*;

    logic [STEP_W-1:0] rem_reg  [DIV_STAGES+1];
    logic [FRAC_W-1:0] quo_reg  [DIV_STAGES+1];
    logic [STEP_W-1:0] den_reg  [DIV_STAGES+1];
    logic              full_reg [DIV_STAGES+1];
    tbi_side_t         side_reg [DIV_STAGES+1];
    logic [DIV_STAGES:0] vld_reg;

    logic [STEP_W-1:0] rem_next [DIV_STAGES];
    logic [FRAC_W-1:0] quo_next [DIV_STAGES];

    logic [STEP_W-1:0] den0;
    logic [STEP_W-1:0] num0;

    // zero length acts as one, step saturates at the segment end
    always_comb
    begin
        den0 = (seg_steps == '0) ? STEP_W'(1) : seg_steps;
        num0 = (step > den0) ? den0 : step;
    end

    // restoring division, DIV_BITS quotient bits per stage
    always_comb
    begin
        logic [STEP_W:0] dbl;
        dbl = '0;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            rem_next[j] = rem_reg[j];
            quo_next[j] = quo_reg[j];
            for (int i = 0; i < DIV_BITS; i++)
            begin
                dbl = {rem_next[j], 1'b0};
                if (dbl >= {1'b0, den_reg[j]})
                begin
                    rem_next[j] = STEP_W'(dbl - {1'b0, den_reg[j]});
                    quo_next[j] = {quo_next[j][FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j] = dbl[STEP_W-1:0];
                    quo_next[j] = {quo_next[j][FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            full_reg[0] <= (num0 == den0);
            rem_reg[0]  <= (num0 == den0) ? '0 : num0;
            quo_reg[0]  <= '0;
            den_reg[0]  <= den0;
            side_reg[0] <= side_in;
            for (int j = 0; j < DIV_STAGES; j++)
            begin
                full_reg[j+1] <= full_reg[j];
                rem_reg[j+1]  <= rem_next[j];
                quo_reg[j+1]  <= quo_next[j];
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES];
    assign side_out  = side_reg[DIV_STAGES];
    assign s = full_reg[DIV_STAGES] ? ONE_Q : {1'b0, quo_reg[DIV_STAGES]};

endmodule

// ----- design/tbi_poly.sv -----
module tbi_poly (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  tbi_pkg::tbi_side_t            side_in,
    input  logic [tbi_pkg::S_W-1:0]       s,
    output logic                          out_valid,
    output tbi_pkg::tbi_side_t            side_out,
    output logic [tbi_pkg::S_W-1:0]       blend
);
    import tbi_pkg::*;

    localparam int PROD_W = 2 * S_W;
    localparam int SUM_W  = S_W + 5;

    logic [4:0] vld_reg;
    tbi_side_t  side_reg [5];

    logic [S_W-1:0] s1_reg, s2_1_reg;
    logic [S_W-1:0] s_2_reg, s2_2_reg, s3_2_reg;
    logic [S_W-1:0] s_3_reg, s2_3_reg, s3_3_reg, s4_3_reg;
    logic [S_W-1:0] s_4_reg, s2_4_reg, s3_4_reg, s4_4_reg, s5_4_reg;
    logic [S_W-1:0] blend_reg;

    logic [PROD_W-1:0] m2, m3, m4, m5;
    logic [SUM_W-1:0]  sum;
    logic [S_W-1:0]    blend_next;

    // powers of s in Q1.24, each truncated, at most one multiply per stage
    assign m2 = s * s;
    assign m3 = s2_1_reg * s1_reg;
    assign m4 = s3_2_reg * s_2_reg;
    assign m5 = s4_3_reg * s_3_reg;

    always_comb
    begin
        case (side_reg[3].mode)
            BLEND_LINEAR:
                sum = SUM_W'(s_4_reg);
            BLEND_CUBIC:
                sum = SUM_W'(s2_4_reg) * SUM_W'(3) - SUM_W'(s3_4_reg) * SUM_W'(2);
            default:
                sum = SUM_W'(s3_4_reg) * SUM_W'(10) - SUM_W'(s4_4_reg) * SUM_W'(15)
                    + SUM_W'(s5_4_reg) * SUM_W'(6);
        endcase
        // clamp to [0, 1]
        if (sum[SUM_W-1])
            blend_next = '0;
        else if (sum > SUM_W'(ONE_Q))
            blend_next = ONE_Q;
        else
            blend_next = sum[S_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int j = 0; j < 4; j++)
            begin
                side_reg[j+1] <= side_reg[j];
            end

            s1_reg   <= s;
            s2_1_reg <= m2[FRAC_W+S_W-1:FRAC_W];

            s_2_reg  <= s1_reg;
            s2_2_reg <= s2_1_reg;
            s3_2_reg <= m3[FRAC_W+S_W-1:FRAC_W];

            s_3_reg  <= s_2_reg;
            s2_3_reg <= s2_2_reg;
            s3_3_reg <= s3_2_reg;
            s4_3_reg <= m4[FRAC_W+S_W-1:FRAC_W];

            s_4_reg  <= s_3_reg;
            s2_4_reg <= s2_3_reg;
            s3_4_reg <= s3_3_reg;
            s4_4_reg <= s4_3_reg;
            s5_4_reg <= m5[FRAC_W+S_W-1:FRAC_W];

            blend_reg <= blend_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign side_out  = side_reg[4];
    assign blend     = blend_reg;

endmodule

// ----- design/tbi_scale.sv -----
module tbi_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  tbi_pkg::tbi_side_t            side_in,
    input  logic [tbi_pkg::S_W-1:0]       blend,
    output logic                          out_valid,
    output logic [tbi_pkg::JOINT_W-1:0]   joint,
    output logic signed [tbi_pkg::POS_W-1:0] position
);
    import tbi_pkg::*;

    localparam int LO_W   = 13;
    localparam int HI_W   = S_W - LO_W;
    localparam int PLO_W  = DIFF_W + LO_W + 1;
    localparam int PHI_W  = DIFF_W + HI_W + 1;
    localparam int PROD_W = DIFF_W + S_W + 1;

    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC_W - 1);

    logic [2:0] vld_reg;

    logic signed [PLO_W-1:0]  p_lo_reg;
    logic signed [PHI_W-1:0]  p_hi_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [POS_W-1:0]  x0_1_reg, x0_2_reg;
    logic [JOINT_W-1:0]       joint_1_reg, joint_2_reg, joint_reg;
    logic signed [POS_W-1:0]  position_reg;

    logic signed [LO_W:0]     b_lo;
    logic signed [HI_W:0]     b_hi;
    logic signed [PLO_W-1:0]  p_lo_next;
    logic signed [PHI_W-1:0]  p_hi_next;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] offset;

    // diff * blend split into two narrower partial products
    assign b_lo      = $signed({1'b0, blend[LO_W-1:0]});
    assign b_hi      = $signed({1'b0, blend[S_W-1:LO_W]});
    assign p_lo_next = side_in.diff * b_lo;
    assign p_hi_next = side_in.diff * b_hi;
    assign prod_next = (PROD_W'(p_hi_reg) <<< LO_W) + PROD_W'(p_lo_reg);

    // round to nearest, ties toward plus infinity
    assign biased = prod_reg + HALF_LSB;
    assign offset = biased >>> FRAC_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg     <= p_lo_next;
            p_hi_reg     <= p_hi_next;
            x0_1_reg     <= side_in.x0;
            joint_1_reg  <= side_in.joint;

            prod_reg     <= prod_next;
            x0_2_reg     <= x0_1_reg;
            joint_2_reg  <= joint_1_reg;

            position_reg <= x0_2_reg + offset[POS_W-1:0];
            joint_reg    <= joint_2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign joint     = joint_reg;
    assign position  = position_reg;

endmodule

// ----- design/trajectory_blend_interpolator.sv -----
// channel  dir  fields                                         width
// req      in   joint_index, start_pos, end_pos, step_index    6, 32, 32, 16
// rsp      out  joint_out, position                            6, 32
// apb      in   blend_mode @0x0, segment_steps @0x4            32-bit data
//
// fully pipelined: one request per cycle unless a result stalls; the pipeline has
// 7 divider stages, 5 blend polynomial stages and 3 scale and round stages
// rst_n clears the valid bits and sets blend_mode 2, segment_steps 100
// a stalled result freezes every stage; req.ready is low only while rsp holds
// a result that is not taken
module trajectory_blend_interpolator (
    input  logic                           clk,
    input  logic                           rst_n,
    tbi_req_if.sink                        req,
    tbi_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbi_pkg::PADDR_W-1:0]    paddr,
    input  logic [tbi_pkg::PDATA_W-1:0]    pwdata,
    output logic [tbi_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import tbi_pkg::*;

    blend_mode_t       blend_mode_reg;
    logic [STEP_W-1:0] segment_steps_reg;

    logic              en;
    logic              cfg_wr;
    tbi_side_t         side_in;

    logic              div_valid;
    tbi_side_t         div_side;
    logic [S_W-1:0]    s;

    logic              poly_valid;
    tbi_side_t         poly_side;
    logic [S_W-1:0]    blend;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg    <= BLEND_QUINTIC;
            segment_steps_reg <= SEGMENT_STEPS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BLEND_MODE:    blend_mode_reg    <= blend_mode_t'(pwdata[1:0]);
                REG_SEGMENT_STEPS: segment_steps_reg <= pwdata[STEP_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BLEND_MODE:    prdata = PDATA_W'(blend_mode_reg);
            REG_SEGMENT_STEPS: prdata = PDATA_W'(segment_steps_reg);
            default:           prdata = '0;
        endcase
    end

    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    always_comb
    begin
        side_in.joint = req.joint_index;
        side_in.x0    = req.start_pos;
        side_in.diff  = {req.end_pos[POS_W-1], req.end_pos}
                      - {req.start_pos[POS_W-1], req.start_pos};
        side_in.mode  = blend_mode_reg;
    end

    tbi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .side_in   (side_in),
        .step      (req.step_index),
        .seg_steps (segment_steps_reg),
        .out_valid (div_valid),
        .side_out  (div_side),
        .s         (s)
    );

    tbi_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .side_in   (div_side),
        .s         (s),
        .out_valid (poly_valid),
        .side_out  (poly_side),
        .blend     (blend)
    );

    tbi_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (poly_valid),
        .side_in   (poly_side),
        .blend     (blend),
        .out_valid (rsp.valid),
        .joint     (rsp.joint_out),
        .position  (rsp.position)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import tbi_pkg::*;

    localparam logic [1:0]              BLEND_UNUSED = 2'd3;
    localparam logic signed [POS_W-1:0] POS_MIN      = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX      = 32'sh7FFF_FFFF;
    localparam longint                  Q_ONE        = longint'(1) << FRAC_W;
    localparam int                      PHASES       = 9;
    localparam int                      PHASE_ITEMS  = 180;
    localparam int                      DRAIN_CYCLES = 40;
    localparam int                      CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] x1;
        logic [STEP_W-1:0]       step;
    } joint_request_t;

    typedef struct {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] position;
    } setpoint_t;

    class setpoint_scoreboard;
        logic [1:0]        cfg_mode;
        logic [STEP_W-1:0] cfg_steps;
        setpoint_t         pending_setpoints[$];
        int unsigned       requests_seen;
        int unsigned       setpoints_checked;
        int unsigned       error_count;

        function new();
            cfg_mode  = BLEND_QUINTIC;
            cfg_steps = SEGMENT_STEPS_RESET;
        endfunction

        function void write_register(logic idx, logic [PDATA_W-1:0] value);
            if (idx == REG_BLEND_MODE)
                cfg_mode = value[1:0];
            else
                cfg_steps = value[STEP_W-1:0];
        endfunction

        function logic signed [POS_W-1:0] blend_position(joint_request_t r);
            longint unsigned n;
            longint unsigned k;
            longint unsigned s;
            longint unsigned s2;
            longint unsigned s3;
            longint unsigned s4;
            longint unsigned s5;
            longint          b;
            longint          d;
            longint          offset;
            n = (cfg_steps == 0) ? 64'd1 : 64'(cfg_steps);
            k = (64'(r.step) > n) ? n : 64'(r.step);
            s = (k << FRAC_W) / n;
            s2 = (s * s) >> FRAC_W;
            s3 = (s2 * s) >> FRAC_W;
            s4 = (s3 * s) >> FRAC_W;
            s5 = (s4 * s) >> FRAC_W;
            if (cfg_mode == BLEND_LINEAR)
                b = longint'(s);
            else if (cfg_mode == BLEND_CUBIC)
                b = 3 * longint'(s2) - 2 * longint'(s3);
            else
                b = (20 * longint'(s3) - 30 * longint'(s4) + 12 * longint'(s5)) / 2;
            if (b < 0)
                b = 0;
            if (b > Q_ONE)
                b = Q_ONE;
            d = longint'(r.x1) - longint'(r.x0);
            // round half toward plus infinity
            offset = (d * b + (Q_ONE >>> 1)) >>> FRAC_W;
            return POS_W'(longint'(r.x0) + offset);
        endfunction

        function void note_request(joint_request_t r);
            setpoint_t sp;
            sp.joint    = r.joint;
            sp.position = blend_position(r);
            pending_setpoints.push_back(sp);
            requests_seen++;
        endfunction

        function void check_result(logic [JOINT_W-1:0] joint, logic signed [POS_W-1:0] pos);
            setpoint_t sp;
            if (pending_setpoints.size() == 0)
            begin
                $error("result with no request outstanding: joint_out %0d position %0d",
                       joint, pos);
                error_count++;
                return;
            end
            sp = pending_setpoints.pop_front();
            setpoints_checked++;
            if (joint !== sp.joint)
            begin
                $error("joint_out mismatch: expected %0d, actual %0d", sp.joint, joint);
                error_count++;
            end
            if (pos !== sp.position)
            begin
                $error("position mismatch: expected %0d, actual %0d", sp.position, pos);
                error_count++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    tbi_req_if req_bus();
    tbi_rsp_if rsp_bus();

    setpoint_scoreboard sb = new();
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;

    trajectory_blend_interpolator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check on the handshake, then pick ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.joint_out, rsp_bus.position);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
        end
    end

    task automatic send_request(input joint_request_t r);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.joint_index <= r.joint;
        req_bus.start_pos   <= r.x0;
        req_bus.end_pos     <= r.x1;
        req_bus.step_index  <= r.step;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic wait_drained();
        while (sb.pending_setpoints.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_register(idx, value);
        @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            1: return POS_W'($urandom_range(0, 4000)) - 32'sd2000;
            default: return $urandom();
        endcase
    endfunction

    function automatic joint_request_t random_request();
        joint_request_t r;
        int unsigned    n;
        n = (sb.cfg_steps == 0) ? 1 : 32'(sb.cfg_steps);
        r.joint = JOINT_W'($urandom_range(0, JOINTS - 1));
        r.x0    = pick_position();
        // short moves in both directions alongside wide ones
        if ($urandom_range(0, 5) == 0)
            r.x1 = r.x0 + POS_W'($urandom_range(0, 512)) - 32'sd256;
        else
            r.x1 = pick_position();
        case ($urandom_range(0, 9))
            0: r.step = '0;
            1: r.step = STEP_W'(n);
            2: r.step = (n < 65535) ? STEP_W'($urandom_range(n + 1, 65535)) : 16'hFFFF;
            3: r.step = 16'hFFFF;
            default: r.step = STEP_W'($urandom_range(0, n));
        endcase
        return r;
    endfunction

    initial
    begin
        logic [1:0]        mode;
        logic [STEP_W-1:0] steps;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.joint_index <= '0;
        req_bus.start_pos   <= '0;
        req_bus.end_pos     <= '0;
        req_bus.step_index  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: quintic blend over 100 steps
        send_request('{joint: 6'd0,  x0: 32'sd0,  x1: 32'sd0,  step: 16'd0});
        send_request('{joint: 6'd63, x0: POS_MIN, x1: POS_MAX, step: 16'd100});
        send_request('{joint: 6'd1,  x0: POS_MAX, x1: POS_MIN, step: 16'd100});
        send_request('{joint: 6'd2,  x0: POS_MIN, x1: POS_MAX, step: 16'd50});
        send_request('{joint: 6'd3,  x0: POS_MAX, x1: POS_MIN, step: 16'd50});
        send_request('{joint: 6'd4,  x0: POS_MIN, x1: POS_MAX, step: 16'd0});
        send_request('{joint: 6'd5,  x0: POS_MAX, x1: POS_MIN, step: 16'd1});
        send_request('{joint: 6'd6,  x0: POS_MIN, x1: POS_MAX, step: 16'd99});
        send_request('{joint: 6'd7,  x0: 32'sd1000, x1: -32'sd5000, step: 16'd101});
        send_request('{joint: 6'd8,  x0: -32'sd77, x1: 32'sd123456, step: 16'hFFFF});
        send_request('{joint: 6'd42, x0: 32'sd12345, x1: 32'sd12345, step: 16'd37});
        // half-way blend times a one-lsb move lands exactly on a rounding tie
        send_request('{joint: 6'd9,  x0: 32'sd0, x1: 32'sd1,  step: 16'd50});
        send_request('{joint: 6'd10, x0: 32'sd0, x1: -32'sd1, step: 16'd50});
        send_request('{joint: 6'd21, x0: 32'sd65536, x1: -32'sd65536, step: 16'd25});
        send_request('{joint: 6'd32, x0: -32'sd1, x1: 32'sd0, step: 16'd75});
        send_request('{joint: 6'd31, x0: 32'sh5555_5555, x1: 32'shAAAA_AAAA, step: 16'hAAAA});

        for (int phase = 0; phase < PHASES; phase++)
        begin
            req_bus.valid <= 1'b0;
            wait_drained();
            case (phase)
                0: begin mode = BLEND_LINEAR;  steps = 16'd1;     end
                1: begin mode = BLEND_CUBIC;   steps = 16'hFFFF;  end
                2: begin mode = BLEND_UNUSED;  steps = 16'd0;     end
                3: begin mode = BLEND_QUINTIC; steps = 16'hFFFF;  end
                4: begin mode = BLEND_CUBIC;   steps = 16'd100;   end
                5: begin mode = BLEND_LINEAR;  steps = STEP_W'($urandom_range(2, 300));  end
                6: begin mode = BLEND_QUINTIC; steps = STEP_W'($urandom_range(2, 1000)); end
                7: begin mode = BLEND_CUBIC;   steps = STEP_W'($urandom_range(1, 65535)); end
                default:
                begin
                    mode  = 2'($urandom_range(0, 3));
                    steps = STEP_W'($urandom_range(1, 65535));
                end
            endcase
            // junk in the unused upper data bits
            write_reg(REG_BLEND_MODE, {30'($urandom()), mode});
            write_reg(REG_SEGMENT_STEPS, {16'($urandom()), steps});
            idle_on = (phase != 4) && (phase != PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 3 && i == PHASE_ITEMS / 2)
                begin
                    req_bus.valid <= 1'b0;
                    wait_drained();
                end
                send_request(random_request());
            end
        end

        req_bus.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d setpoints checked, over %0d register settings",
                 sb.requests_seen, sb.setpoints_checked, PHASES + 1);
        $display("all blend modes incl. the unused code, zero, one and full-length segments");
        if (sb.error_count == 0 && sb.pending_setpoints.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tbi_pkg.sv
design/tbi_req_if.sv
design/tbi_rsp_if.sv
design/tbi_div.sv
design/tbi_poly.sv
design/tbi_scale.sv
design/trajectory_blend_interpolator.sv
dv/tb_top.sv
